// ===== hdl/box_resolution_weight_unit_macros.svh =====
// Assertion macros for the box resolution weight unit.
// Included by the files that carry concurrent assertions; no other dependency.
`ifndef BOX_RESOLUTION_WEIGHT_UNIT_MACROS_SVH
`define BOX_RESOLUTION_WEIGHT_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define BRW_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BRW_ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ===== hdl/brw_pkg.sv =====
// Shared types, constants and stage counts for the box resolution weight unit.
// No dependencies; imported by every other file except the macros header.
`timescale 1ns / 1ps

package brw_pkg;

   localparam int COORD_BITS       = 21;
   localparam int WEIGHT_FRAC_BITS = 15;
   localparam int CFG_W            = 3 * COORD_BITS;
   localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
   localparam int CSR_INDEX_W      = 3;
   localparam int MODE_W           = 2;

   localparam int Q_FRAC = 30;
   localparam int FIX_W  = Q_FRAC + 1;
   localparam logic [FIX_W-1:0] ONE_Q30 = {1'b1, {Q_FRAC{1'b0}}};

   localparam int DIST_W    = COORD_BITS;
   localparam int SQR_W     = 2 * COORD_BITS;
   localparam int SUM_W     = 2 * COORD_BITS + 2;
   localparam int RAD_W     = 64;
   localparam int RAD_SHIFT = 16;
   localparam int SQ_CELLS  = RAD_W / 2;
   localparam int ROOT_W    = 31;
   localparam int DIV_CELLS = Q_FRAC + 1;
   localparam int COS_CELLS = 7;

   localparam int ROUND_SH = Q_FRAC - WEIGHT_FRAC_BITS;
   localparam logic [31:0] ROUND_ADD = (32'd1 << ROUND_SH) >> 1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   localparam logic [FIX_W-1:0] HORNER_INIT = 31'd7;
   localparam logic [FIX_W-1:0] HORNER_COEF [COS_CELLS] = '{
      31'd506, 31'd27060, 31'd987048, 31'd22401992, 31'd272375560,
      31'd1324675879, ONE_Q30
   };

   // pipeline positions on the sideband line, stage four is position zero
   localparam int SQ_END    = SQ_CELLS;
   localparam int DIV_END   = SQ_END + DIV_CELLS;
   localparam int U_IDX     = DIV_END + 1;
   localparam int COS_END   = U_IDX + COS_CELLS;
   localparam int MIX_IDX   = COS_END + 1;
   localparam int SEL_IDX   = MIX_IDX + 1;
   localparam int OUT_IDX   = SEL_IDX + 1;
   localparam int LINE_LEN  = OUT_IDX + 1;

   typedef enum logic [1:0] {
      ZONE_INNER   = 2'd0,
      ZONE_SHELL   = 2'd1,
      ZONE_OUTSIDE = 2'd2
   } zone_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NEAREST   = 2'd0,
      MODE_COMPONENT = 2'd1,
      MODE_FLAT      = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INNER_LOW    = 3'd0,
      CSR_INNER_HIGH   = 3'd1,
      CSR_SHELL_LOW    = 3'd2,
      CSR_SHELL_HIGH   = 3'd3,
      CSR_SHELL_WIDTHS = 3'd4,
      CSR_WEIGHT_MODE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      zone_type         zone;
      logic [2:0]       skip;
      logic [2:0]       sat;
      logic             near_ok;
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [RAD_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [ROOT_W-1:0]    rem;
      logic [DIV_CELLS-1:0] num;
      logic [DIV_CELLS-1:0] quot;
      logic [ROOT_W-1:0]    den;
   } div_type;

   typedef struct packed {
      logic [FIX_W-1:0] acc;
      logic [FIX_W-1:0] u;
   } cos_type;

endpackage

// ===== hdl/brw_intf.sv =====
// Channel interfaces: position requests, weight responses, register writes.
// Depends on brw_pkg.
`timescale 1ns / 1ps

interface brw_req_if import brw_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface brw_rsp_if import brw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] weight;
   zone_type            zone;
   modport source (output valid, weight, zone, input ready);
   modport sink (input valid, weight, zone, output ready);
endinterface

interface brw_csr_if import brw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/brw_sqrt_cell.sv =====
// One digit step of the integer square root chain.
// Depends on brw_pkg.
`timescale 1ns / 1ps

module brw_sqrt_cell import brw_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [RAD_W-1:0] step_bit,
   input  sqrt_type         cell_i,
   output sqrt_type         cell_o
);

   sqrt_type         cell_ff, cell_in;
   logic [RAD_W-1:0] trial;

   always_comb begin
      trial   = cell_i.root + step_bit;
      cell_in = cell_i;
      if (cell_i.rad >= trial) begin
         cell_in.rad  = cell_i.rad - trial;
         cell_in.root = (cell_i.root >> 1) + step_bit;
      end else begin
         cell_in.root = cell_i.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule

// ===== hdl/brw_div_cell.sv =====
// One quotient bit of the restoring divider chain.
// Depends on brw_pkg.
`timescale 1ns / 1ps

module brw_div_cell import brw_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  div_type cell_i,
   output div_type cell_o
);

   div_type         cell_ff, cell_in;
   logic [ROOT_W:0] trial;
   logic            qbit;

   always_comb begin
      trial   = {cell_i.rem, cell_i.num[DIV_CELLS-1]};
      qbit    = (trial >= {1'b0, cell_i.den});
      cell_in = cell_i;
      cell_in.rem  = qbit ? ROOT_W'(trial - {1'b0, cell_i.den}) : ROOT_W'(trial);
      cell_in.num  = cell_i.num << 1;
      cell_in.quot = {cell_i.quot[DIV_CELLS-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (en) cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule

// ===== hdl/brw_cos_cell.sv =====
// One Horner step of the cosine polynomial chain.
// Depends on brw_pkg.
`timescale 1ns / 1ps

module brw_cos_cell import brw_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [FIX_W-1:0] coef,
   input  cos_type          cell_i,
   output cos_type          cell_o
);

   cos_type            cell_ff, cell_in;
   logic [2*FIX_W-1:0] prod;
   logic [FIX_W-1:0]   part;

   always_comb begin
      prod        = cell_i.acc * cell_i.u;
      part        = prod[Q_FRAC +: FIX_W];
      cell_in     = cell_i;
      cell_in.acc = (part >= coef) ? '0 : coef - part;
   end

   always_ff @(posedge clock) begin
      if (en) cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule

// ===== hdl/box_resolution_weight_unit.sv =====
// Top level of the box resolution weight unit: registers, box tests, cell chains.
// Depends on brw_pkg, brw_intf, the three cell modules and the macros header.
//
//   channel   dir   words
//   req_bus   in    pos_x, pos_y, pos_z
//   rsp_bus   out   weight, zone
//   csr_bus   in    index, data
//
// One word enters per cycle while the response is not stalled; its path runs through
// the chains of 32 square root cells, 31 divider cells and 7 cosine cells.
// Reset clears the configuration registers and all stage valid bits.
// A stalled response freezes the whole pipeline; req_bus.ready follows it.
`timescale 1ns / 1ps
`include "box_resolution_weight_unit_macros.svh"

module box_resolution_weight_unit import brw_pkg::*; (
   input  logic clock,
   input  logic reset,
   brw_req_if.sink   req_bus,
   brw_rsp_if.source rsp_bus,
   brw_csr_if.sink   csr_bus
);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [2:0][DIST_W-1:0] gap;
      logic [2:0][DIST_W-1:0] width;
   } geo_type;

   function automatic coord_type field_s(logic [CFG_W-1:0] r, int k);
      return coord_type'(r[k*COORD_BITS +: COORD_BITS]);
   endfunction

   logic [CFG_W-1:0]  inner_low_ff, inner_high_ff, shell_low_ff, shell_high_ff;
   logic [CFG_W-1:0]  shell_widths_ff;
   logic [MODE_W-1:0] weight_mode_ff;
   logic              en;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_low_ff    <= '0;
         inner_high_ff   <= '0;
         shell_low_ff    <= '0;
         shell_high_ff   <= '0;
         shell_widths_ff <= '0;
         weight_mode_ff  <= '0;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_INNER_LOW:    inner_low_ff    <= csr_bus.data;
            CSR_INNER_HIGH:   inner_high_ff   <= csr_bus.data;
            CSR_SHELL_LOW:    shell_low_ff    <= csr_bus.data;
            CSR_SHELL_HIGH:   shell_high_ff   <= csr_bus.data;
            CSR_SHELL_WIDTHS: shell_widths_ff <= csr_bus.data;
            CSR_WEIGHT_MODE:  weight_mode_ff  <= csr_bus.data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   side_type side_ff [LINE_LEN];

   assign en            = !side_ff[OUT_IDX].valid || rsp_bus.ready;
   assign req_bus.ready = en;

   // stage 1: capture
   logic           s1_valid_ff;
   coord_type      s1_pos_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (en) s1_valid_ff <= req_bus.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pos_ff[0] <= req_bus.pos_x;
         s1_pos_ff[1] <= req_bus.pos_y;
         s1_pos_ff[2] <= req_bus.pos_z;
      end
   end

   // stage 2: box tests and axis distances
   logic                      in_inner, in_shell;
   zone_type                  zone_in;
   logic [2:0][DIST_W-1:0]    dist_in, width_in;
   logic [2:0]                skip_in, sat_in;
   logic signed [COORD_BITS:0] diff_a, diff_b, diff_m;

   always_comb begin
      in_inner = 1'b1;
      in_shell = 1'b1;
      dist_in  = '0;
      width_in = '0;
      skip_in  = '0;
      sat_in   = '0;
      diff_a   = '0;
      diff_b   = '0;
      diff_m   = '0;
      for (int k = 0; k < 3; k++) begin
         if (s1_pos_ff[k] < field_s(inner_low_ff, k) ||
             s1_pos_ff[k] > field_s(inner_high_ff, k)) in_inner = 1'b0;
         if (s1_pos_ff[k] < field_s(shell_low_ff, k) ||
             s1_pos_ff[k] > field_s(shell_high_ff, k)) in_shell = 1'b0;
         diff_a = (COORD_BITS+1)'(field_s(inner_low_ff, k)) -
                  (COORD_BITS+1)'(s1_pos_ff[k]);
         diff_b = (COORD_BITS+1)'(s1_pos_ff[k]) -
                  (COORD_BITS+1)'(field_s(inner_high_ff, k));
         diff_m = (diff_a > diff_b) ? diff_a : diff_b;
         dist_in[k]  = (diff_m > 0) ? diff_m[DIST_W-1:0] : '0;
         width_in[k] = shell_widths_ff[k*COORD_BITS +: COORD_BITS];
         skip_in[k]  = (width_in[k] == '0) || (dist_in[k] == '0);
         sat_in[k]   = (dist_in[k] >= width_in[k]);
      end
      if (in_inner) zone_in = ZONE_INNER;
      else if (!in_shell) zone_in = ZONE_OUTSIDE;
      else zone_in = ZONE_SHELL;
   end

   logic     s2_valid_ff;
   zone_type s2_zone_ff;
   logic [2:0] s2_skip_ff, s2_sat_ff;
   geo_type  s2_geo_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (en) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_zone_ff      <= zone_in;
         s2_skip_ff      <= skip_in;
         s2_sat_ff       <= sat_in;
         s2_geo_ff.gap   <= dist_in;
         s2_geo_ff.width <= width_in;
      end
   end

   // stage 3: squares
   logic       s3_valid_ff;
   zone_type   s3_zone_ff;
   logic [2:0] s3_skip_ff, s3_sat_ff;
   geo_type    s3_geo_ff;
   logic [2:0][SQR_W-1:0] s3_dsq_ff, s3_hsq_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (en) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_zone_ff <= s2_zone_ff;
         s3_skip_ff <= s2_skip_ff;
         s3_sat_ff  <= s2_sat_ff;
         s3_geo_ff  <= s2_geo_ff;
         for (int k = 0; k < 3; k++) begin
            s3_dsq_ff[k] <= s2_geo_ff.gap[k] * s2_geo_ff.gap[k];
            s3_hsq_ff[k] <= (s2_geo_ff.gap[k] != '0) ?
                            s2_geo_ff.width[k] * s2_geo_ff.width[k] : '0;
         end
      end
   end

   // stage 4: sums, start of the sideband line
   logic [SUM_W-1:0] d2_sum, h2_sum;
   logic [SUM_W-1:0] d2_ff, h2_ff;
   side_type         side_in0;
   geo_type          geo_ff [SQ_END+1];

   always_comb begin
      d2_sum = SUM_W'(s3_dsq_ff[0]) + SUM_W'(s3_dsq_ff[1]) + SUM_W'(s3_dsq_ff[2]);
      h2_sum = SUM_W'(s3_hsq_ff[0]) + SUM_W'(s3_hsq_ff[1]) + SUM_W'(s3_hsq_ff[2]);
      side_in0.valid   = s3_valid_ff;
      side_in0.zone    = s3_zone_ff;
      side_in0.skip    = s3_skip_ff;
      side_in0.sat     = s3_sat_ff;
      side_in0.near_ok = (d2_sum < h2_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_LEN; i++) side_ff[i].valid <= 1'b0;
      end else if (en) begin
         side_ff[0] <= side_in0;
         for (int i = 1; i < LINE_LEN; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff     <= d2_sum;
         h2_ff     <= h2_sum;
         geo_ff[0] <= s3_geo_ff;
         for (int j = 1; j <= SQ_END; j++) geo_ff[j] <= geo_ff[j-1];
      end
   end

   // square root chains: lane 0 distance, lane 1 hybrid width
   sqrt_type sq_link [2][SQ_CELLS+1];

   always_comb begin
      sq_link[0][0].rad  = RAD_W'(d2_ff) << RAD_SHIFT;
      sq_link[0][0].root = '0;
      sq_link[1][0].rad  = RAD_W'(h2_ff) << RAD_SHIFT;
      sq_link[1][0].root = '0;
   end

   for (genvar l = 0; l < 2; l++) begin : g_sq_lane
      for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq_cell
         brw_sqrt_cell u_cell (
            .clock    (clock),
            .en       (en),
            .step_bit (RAD_W'(1) << (RAD_W - 2 - 2 * i)),
            .cell_i   (sq_link[l][i]),
            .cell_o   (sq_link[l][i+1])
         );
      end
   end

   // divider chains: lane 0 serves nearest mode or the x axis
   div_type           div_link [3][DIV_CELLS+1];
   logic [ROOT_W-1:0] div_x [3];
   logic [ROOT_W-1:0] div_d [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         div_x[k] = ROOT_W'(geo_ff[SQ_END].gap[k]);
         div_d[k] = ROOT_W'(geo_ff[SQ_END].width[k]);
      end
      if (mode_type'(weight_mode_ff) == MODE_NEAREST) begin
         div_x[0] = ROOT_W'(sq_link[0][SQ_CELLS].root);
         div_d[0] = ROOT_W'(sq_link[1][SQ_CELLS].root);
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_div_lane
      assign div_link[l][0] = {ROOT_W'(div_x[l] >> 1), div_x[l][0], (DIV_CELLS-1)'(0),
                               DIV_CELLS'(0), div_d[l]};
      for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div_cell
         brw_div_cell u_cell (
            .clock  (clock),
            .en     (en),
            .cell_i (div_link[l][i]),
            .cell_o (div_link[l][i+1])
         );
      end
   end

   // cosine: phase square, then Horner chain
   cos_type            cos_link [3][COS_CELLS+1];
   cos_type            u_ff [3];
   logic [FIX_W-1:0]   phase [3];
   logic [2*FIX_W-1:0] phase_sq [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         phase[k]    = (div_link[k][DIV_CELLS].quot > ONE_Q30) ? ONE_Q30 :
                       div_link[k][DIV_CELLS].quot;
         phase_sq[k] = phase[k] * phase[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            u_ff[k].acc <= HORNER_INIT;
            u_ff[k].u   <= phase_sq[k][Q_FRAC +: FIX_W];
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_cos_lane
      assign cos_link[l][0] = u_ff[l];
      for (genvar i = 0; i < COS_CELLS; i++) begin : g_cos_cell
         brw_cos_cell u_cell (
            .clock  (clock),
            .en     (en),
            .coef   (HORNER_COEF[i]),
            .cell_i (cos_link[l][i]),
            .cell_o (cos_link[l][i+1])
         );
      end
   end

   // combine
   logic [FIX_W-1:0]   factor [3];
   logic [2*FIX_W-1:0] near_prod, m01_prod, comp_prod;
   logic [FIX_W-1:0]   near_w_ff, m01_ff, f2_ff, w_ff, w_sel;
   logic [WEIGHT_W-1:0] weight_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (side_ff[COS_END].skip[k]) factor[k] = ONE_Q30;
         else if (side_ff[COS_END].sat[k]) factor[k] = '0;
         else factor[k] = cos_link[k][COS_CELLS].acc;
      end
      near_prod = cos_link[0][COS_CELLS].acc * cos_link[0][COS_CELLS].acc;
      m01_prod  = factor[0] * factor[1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         near_w_ff <= near_prod[Q_FRAC +: FIX_W];
         m01_ff    <= m01_prod[Q_FRAC +: FIX_W];
         f2_ff     <= factor[2];
      end
   end

   always_comb begin
      comp_prod = m01_ff * f2_ff;
      case (side_ff[MIX_IDX].zone)
         ZONE_INNER: w_sel = ONE_Q30;
         ZONE_SHELL: begin
            case (mode_type'(weight_mode_ff))
               MODE_NEAREST:   w_sel = side_ff[MIX_IDX].near_ok ? near_w_ff : '0;
               MODE_COMPONENT: w_sel = comp_prod[Q_FRAC +: FIX_W];
               default:        w_sel = '0;
            endcase
         end
         default: w_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff      <= w_sel;
         weight_ff <= WEIGHT_W'((32'(w_ff) + ROUND_ADD) >> ROUND_SH);
      end
   end

   assign rsp_bus.valid  = side_ff[OUT_IDX].valid;
   assign rsp_bus.weight = weight_ff;
   assign rsp_bus.zone   = side_ff[OUT_IDX].zone;

   `BRW_ASSERT_IMPLIES(a_stall_holds_input, clock, reset, rsp_bus.valid && !rsp_bus.ready, !req_bus.ready, "stalled response did not block input")
   `BRW_ASSERT_IMPLIES(a_inner_full, clock, reset, rsp_bus.valid && rsp_bus.zone == ZONE_INNER, rsp_bus.weight == WEIGHT_ONE, "inner box word without full weight")
   `BRW_ASSERT_IMPLIES(a_outside_zero, clock, reset, rsp_bus.valid && rsp_bus.zone == ZONE_OUTSIDE, rsp_bus.weight == '0, "outside word with nonzero weight")
   `BRW_ASSERT_IMPLIES(a_weight_range, clock, reset, rsp_bus.valid, rsp_bus.weight <= WEIGHT_ONE, "weight above one")

endmodule
